>>> sv/mtcc_pkg.sv
// Package with the shared types, constants and tables of the millisecond calendar clock.
`timescale 1ns / 1ps

package mtcc_pkg;

    // Field limits of the calendar cascade.
    localparam logic [9:0] MS_MAX     = 10'd999;
    localparam logic [5:0] SEC_MAX    = 6'd59;
    localparam logic [5:0] MIN_MAX    = 6'd59;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [4:0] DAY_FEB    = 5'd28;
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [2:0] WDAY_MAX   = 3'd7;

    // Reset values of the calendar.
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [2:0] WDAY_FIRST  = 3'd1;

    // Prescaler width and default period of the 100 ms pulse.
    localparam int PRESC_W            = 7;
    localparam int PULSE_DIVIDE_DEF   = 100;

    // Operation carried by an input beat.
    typedef enum logic [0:0] {
        ACT_TICK = 1'b0,
        ACT_LOAD = 1'b1
    } t_action;

    // Input beat.
    typedef struct packed {
        t_action     action;
        logic [9:0]  load_millisecond;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [4:0]  load_hour;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [6:0]  load_year;
        logic [2:0]  load_weekday;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [9:0]  millisecond;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
        logic [2:0]  weekday;
        logic        pulse_100ms;
        logic [31:0] tick_count;
    } t_out;

    // Architectural state of the clock.
    typedef struct packed {
        logic [9:0]         ms;
        logic [5:0]         sec;
        logic [5:0]         min;
        logic [4:0]         hour;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [6:0]         year;
        logic [2:0]         wday;
        logic [PRESC_W-1:0] presc;
        logic [31:0]        ticks;
    } t_state;

    // Days in each month; a month of zero reads as January.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> sv/mtcc_step.sv
// Single-pass next-state logic of the calendar clock for one input beat.
`timescale 1ns / 1ps

module mtcc_step #(
    parameter int PULSE_DIVIDE = mtcc_pkg::PULSE_DIVIDE_DEF
) (
    input  mtcc_pkg::t_state i_cur,
    input  mtcc_pkg::t_in    i_beat,
    output mtcc_pkg::t_state o_next,
    output logic             o_pulse
);

    logic [mtcc_pkg::PRESC_W-1:0] presc_inc;
    logic [3:0]                   month_fix;
    logic [4:0]                   day_limit;
    logic [4:0]                   day_nxt;
    logic [3:0]                   month_nxt;
    logic [6:0]                   year_nxt;
    logic [2:0]                   wday_nxt;

    // Day change: weekday, month correction, month-length rollover and year.
    always_comb begin
        wday_nxt = (i_cur.wday == mtcc_pkg::WDAY_MAX) ? mtcc_pkg::WDAY_FIRST
                                                      : i_cur.wday + 3'd1;
        if (i_cur.month > mtcc_pkg::MONTH_MAX || i_cur.month == 4'd0) begin
            month_fix = mtcc_pkg::MONTH_FIRST;
        end else begin
            month_fix = i_cur.month;
        end
        day_limit = mtcc_pkg::month_len(month_fix);
        // February of a year divisible by four gets a 29th day.
        if (month_fix == mtcc_pkg::MONTH_FEB && i_cur.day == mtcc_pkg::DAY_FEB &&
            i_cur.year[1:0] == 2'b00) begin
            day_limit = day_limit + 5'd1;
        end
        day_nxt   = i_cur.day;
        month_nxt = month_fix;
        year_nxt  = i_cur.year;
        if (i_cur.day < day_limit) begin
            day_nxt = i_cur.day + 5'd1;
        end else begin
            day_nxt = mtcc_pkg::DAY_FIRST;
            if (month_fix < mtcc_pkg::MONTH_MAX) begin
                month_nxt = month_fix + 4'd1;
            end else begin
                month_nxt = mtcc_pkg::MONTH_FIRST;
                year_nxt  = (i_cur.year >= mtcc_pkg::YEAR_MAX) ? 7'd0 : i_cur.year + 7'd1;
            end
        end
    end

    // Load or tick: the tick runs the prescaler, the tick count and the cascade.
    always_comb begin
        o_next    = i_cur;
        o_pulse   = 1'b0;
        presc_inc = i_cur.presc + mtcc_pkg::PRESC_W'(1);
        if (i_beat.action == mtcc_pkg::ACT_LOAD) begin
            o_next.ms    = i_beat.load_millisecond;
            o_next.sec   = i_beat.load_second;
            o_next.min   = i_beat.load_minute;
            o_next.hour  = i_beat.load_hour;
            o_next.day   = i_beat.load_day;
            o_next.month = i_beat.load_month;
            o_next.year  = i_beat.load_year;
            o_next.wday  = i_beat.load_weekday;
        end else begin
            o_next.ticks = i_cur.ticks + 32'd1;
            if (presc_inc >= mtcc_pkg::PRESC_W'(PULSE_DIVIDE)) begin
                o_next.presc = '0;
                o_pulse      = 1'b1;
            end else begin
                o_next.presc = presc_inc;
            end
            if (i_cur.ms < mtcc_pkg::MS_MAX) begin
                o_next.ms = i_cur.ms + 10'd1;
            end else begin
                o_next.ms = '0;
                if (i_cur.sec < mtcc_pkg::SEC_MAX) begin
                    o_next.sec = i_cur.sec + 6'd1;
                end else begin
                    o_next.sec = '0;
                    if (i_cur.min < mtcc_pkg::MIN_MAX) begin
                        o_next.min = i_cur.min + 6'd1;
                    end else begin
                        o_next.min = '0;
                        if (i_cur.hour < mtcc_pkg::HOUR_MAX) begin
                            o_next.hour = i_cur.hour + 5'd1;
                        end else begin
                            o_next.hour  = '0;
                            o_next.day   = day_nxt;
                            o_next.month = month_nxt;
                            o_next.year  = year_nxt;
                            o_next.wday  = wday_nxt;
                        end
                    end
                end
            end
        end
    end

endmodule

>>> sv/ms_tick_calendar_clock_top.sv
// Top level of the millisecond calendar clock: state, result register and skid stage.
`timescale 1ns / 1ps
// The result of an accepted beat is registered in the result register, or in the skid register while that one is full.
// Throughput: one beat per cycle while the skid register is empty; the calendar update is one pass of next-state logic.
// A result register plus a skid register take one extra beat while the output stalls.
// Reset (synchronous, active low): 00:00:00.000, day 1, month 1, year 0, weekday 1,
// prescaler and tick count zero, no result pending.

module ms_tick_calendar_clock_top #(
    parameter int PULSE_DIVIDE = mtcc_pkg::PULSE_DIVIDE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mtcc_pkg::t_in  i_data,
    output logic           o_stall,
    output logic           o_valid,
    output mtcc_pkg::t_out o_data,
    input  logic           i_stall
);

    mtcc_pkg::t_state r_state;
    mtcc_pkg::t_state n_state;
    mtcc_pkg::t_out   r_out;
    mtcc_pkg::t_out   n_out;
    mtcc_pkg::t_out   r_skid;
    mtcc_pkg::t_out   n_skid;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_skid_valid;
    logic             n_skid_valid;
    mtcc_pkg::t_state step_next;
    mtcc_pkg::t_out   step_res;
    logic             step_pulse;
    logic             in_acc;
    logic             out_acc;

    // Handshake: the skid register being full holds off the upstream side.
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign in_acc  = i_valid && !r_skid_valid;
    assign out_acc = r_out_valid && !i_stall;

    // Calendar update for the beat on the input.
    mtcc_step #(
        .PULSE_DIVIDE(PULSE_DIVIDE)
    ) u_step (
        .i_cur  (r_state),
        .i_beat (i_data),
        .o_next (step_next),
        .o_pulse(step_pulse)
    );

    // Result beat built from the updated state.
    always_comb begin
        step_res.millisecond = step_next.ms;
        step_res.second      = step_next.sec;
        step_res.minute      = step_next.min;
        step_res.hour        = step_next.hour;
        step_res.day         = step_next.day;
        step_res.month       = step_next.month;
        step_res.year        = step_next.year;
        step_res.weekday     = step_next.wday;
        step_res.pulse_100ms = step_pulse;
        step_res.tick_count  = step_next.ticks;
    end

    // State advances only on an accepted beat.
    always_comb begin
        n_state = in_acc ? step_next : r_state;
    end

    // Output register and skid register steering.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_acc) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (in_acc) begin
                n_out = step_res;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_acc) begin
            if (!r_out_valid) begin
                n_out       = step_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = step_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    // Control and architectural state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.ms    <= '0;
            r_state.sec   <= '0;
            r_state.min   <= '0;
            r_state.hour  <= '0;
            r_state.day   <= mtcc_pkg::DAY_FIRST;
            r_state.month <= mtcc_pkg::MONTH_FIRST;
            r_state.year  <= '0;
            r_state.wday  <= mtcc_pkg::WDAY_FIRST;
            r_state.presc <= '0;
            r_state.ticks <= '0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

`ifndef SYNTH
    // The skid register only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held without a result beat");

    // Reset empties both output stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_skid_valid))
        else $error("output stages not empty after reset");

    // Every accepted tick advances the tick count by exactly one.
    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.action == mtcc_pkg::ACT_TICK) |=>
            (r_state.ticks == $past(r_state.ticks) + 32'd1))
        else $error("tick count did not advance on a tick beat");

    // A load beat leaves the tick count and the prescaler alone.
    a_load_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.action == mtcc_pkg::ACT_LOAD) |=>
            ($stable(r_state.ticks) && $stable(r_state.presc)))
        else $error("load beat disturbed the tick count or prescaler");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench of the millisecond calendar clock: directed and random beats against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int TOTAL_BEATS    = 1250;
    localparam int CALM_BEATS     = 150;
    localparam int HOLD_AT        = 500;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;

    // Calendar predictor and the queue of calendar times it expects back.
    class calendar_scoreboard;
        logic [9:0]     cal_ms;
        logic [5:0]     cal_sec;
        logic [5:0]     cal_min;
        logic [4:0]     cal_hour;
        logic [4:0]     cal_day;
        logic [3:0]     cal_month;
        logic [6:0]     cal_year;
        logic [2:0]     cal_wday;
        logic [6:0]     cal_presc;
        logic [31:0]    cal_ticks;
        logic [4:0]     month_days [0:12];
        mtcc_pkg::t_out expected_times [$];
        int             mismatches;

        function new();
            cal_ms     = '0;
            cal_sec    = '0;
            cal_min    = '0;
            cal_hour   = '0;
            cal_day    = mtcc_pkg::DAY_FIRST;
            cal_month  = mtcc_pkg::MONTH_FIRST;
            cal_year   = '0;
            cal_wday   = mtcc_pkg::WDAY_FIRST;
            cal_presc  = '0;
            cal_ticks  = '0;
            mismatches = 0;
            // Index zero stands in for a month that was never valid.
            month_days = '{5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                           5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
        endfunction

        // Apply one accepted beat to the calendar and queue the time it leaves behind.
        function void advance_calendar(mtcc_pkg::t_in beat);
            logic [4:0]     last_day;
            logic           pulse;
            mtcc_pkg::t_out want;
            pulse = 1'b0;
            if (beat.action == mtcc_pkg::ACT_LOAD) begin
                cal_ms    = beat.load_millisecond;
                cal_sec   = beat.load_second;
                cal_min   = beat.load_minute;
                cal_hour  = beat.load_hour;
                cal_day   = beat.load_day;
                cal_month = beat.load_month;
                cal_year  = beat.load_year;
                cal_wday  = beat.load_weekday;
            end else begin
                cal_ticks = cal_ticks + 32'd1;
                cal_presc = cal_presc + 7'd1;
                if (int'(cal_presc) >= mtcc_pkg::PULSE_DIVIDE_DEF) begin
                    cal_presc = '0;
                    pulse     = 1'b1;
                end
                // Cascade: each field wraps at or above its limit and carries on.
                if (cal_ms >= mtcc_pkg::MS_MAX) begin
                    cal_ms = '0;
                    if (cal_sec >= mtcc_pkg::SEC_MAX) begin
                        cal_sec = '0;
                        if (cal_min >= mtcc_pkg::MIN_MAX) begin
                            cal_min = '0;
                            if (cal_hour >= mtcc_pkg::HOUR_MAX) begin
                                cal_hour = '0;
                                // Day change.
                                cal_wday = (cal_wday == mtcc_pkg::WDAY_MAX) ?
                                           mtcc_pkg::WDAY_FIRST : cal_wday + 3'd1;
                                if (cal_month > mtcc_pkg::MONTH_MAX || cal_month == 4'd0) begin
                                    cal_month = mtcc_pkg::MONTH_FIRST;
                                end
                                last_day = month_days[cal_month];
                                // Only the 28th of February sees the leap day.
                                if (cal_month == mtcc_pkg::MONTH_FEB &&
                                    cal_day == mtcc_pkg::DAY_FEB &&
                                    cal_year[1:0] == 2'b00) begin
                                    last_day = last_day + 5'd1;
                                end
                                if (cal_day < last_day) begin
                                    cal_day = cal_day + 5'd1;
                                end else begin
                                    cal_day = mtcc_pkg::DAY_FIRST;
                                    if (cal_month < mtcc_pkg::MONTH_MAX) begin
                                        cal_month = cal_month + 4'd1;
                                    end else begin
                                        cal_month = mtcc_pkg::MONTH_FIRST;
                                        cal_year  = (cal_year >= mtcc_pkg::YEAR_MAX) ? 7'd0 :
                                                    cal_year + 7'd1;
                                    end
                                end
                            end else begin
                                cal_hour = cal_hour + 5'd1;
                            end
                        end else begin
                            cal_min = cal_min + 6'd1;
                        end
                    end else begin
                        cal_sec = cal_sec + 6'd1;
                    end
                end else begin
                    cal_ms = cal_ms + 10'd1;
                end
            end
            want.millisecond = cal_ms;
            want.second      = cal_sec;
            want.minute      = cal_min;
            want.hour        = cal_hour;
            want.day         = cal_day;
            want.month       = cal_month;
            want.year        = cal_year;
            want.weekday     = cal_wday;
            want.pulse_100ms = pulse;
            want.tick_count  = cal_ticks;
            expected_times.push_back(want);
        endfunction

        function string show(mtcc_pkg::t_out t);
            return $sformatf({"%0d:%0d:%0d.%0d day %0d month %0d year %0d",
                              " wday %0d pulse %0d ticks %0d"},
                             t.hour, t.minute, t.second, t.millisecond, t.day, t.month,
                             t.year, t.weekday, t.pulse_100ms, t.tick_count);
        endfunction

        // Compare one result beat with the oldest expected time.
        function void check_result(mtcc_pkg::t_out got);
            mtcc_pkg::t_out want;
            if (expected_times.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: unexpected result beat: %s", show(got));
                end
                return;
            end
            want = expected_times.pop_front();
            if (got.millisecond !== want.millisecond || got.second !== want.second ||
                got.minute !== want.minute || got.hour !== want.hour ||
                got.day !== want.day || got.month !== want.month ||
                got.year !== want.year || got.weekday !== want.weekday ||
                got.pulse_100ms !== want.pulse_100ms || got.tick_count !== want.tick_count) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: expected %s", show(want));
                    $display("       got      %s", show(got));
                end
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           i_stall;
    logic           o_stall;
    logic           o_valid;
    mtcc_pkg::t_in  i_data;
    mtcc_pkg::t_out o_data;

    calendar_scoreboard sb;
    int beats_in    = 0;
    int send_odds   = 2;
    int stall_odds  = 2;
    int quiet_cycles = 0;
    bit calm_tail   = 1'b0;
    bit hold_done   = 1'b0;

    ms_tick_calendar_clock_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always #5 i_clk = ~i_clk;

    // Tick beat with random content in the fields a tick ignores.
    function automatic mtcc_pkg::t_in tick_beat();
        logic [63:0]   raw;
        mtcc_pkg::t_in beat;
        raw         = {$urandom, $urandom};
        beat        = raw[$bits(mtcc_pkg::t_in)-1:0];
        beat.action = mtcc_pkg::ACT_TICK;
        return beat;
    endfunction

    function automatic mtcc_pkg::t_in load_beat(int ms, int sec, int mnt, int hr,
                                                int dd, int mon, int yr, int wd);
        mtcc_pkg::t_in beat;
        beat.action           = mtcc_pkg::ACT_LOAD;
        beat.load_millisecond = 10'(ms);
        beat.load_second      = 6'(sec);
        beat.load_minute      = 6'(mnt);
        beat.load_hour        = 5'(hr);
        beat.load_day         = 5'(dd);
        beat.load_month       = 4'(mon);
        beat.load_year        = 7'(yr);
        beat.load_weekday     = 3'(wd);
        return beat;
    endfunction

    // Mostly the wrap value, sometimes above it, sometimes anywhere in the field.
    function automatic int rand_near(int top, int full);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return top;
        if (pick < 8) return $urandom_range(top, full);
        return $urandom_range(0, full);
    endfunction

    // Offer one beat, with an occasional idle burst first, and wait until it is taken.
    task automatic send_beat(input mtcc_pkg::t_in beat);
        if (beats_in % 50 == 0) send_odds = $urandom_range(0, 4);
        if (!calm_tail && $urandom_range(1, 16) <= send_odds) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.advance_calendar(beat);
        beats_in++;
    endtask

    task automatic load_and_tick(input int ms, input int sec, input int mnt, input int hr,
                                 input int dd, input int mon, input int yr, input int wd);
        send_beat(load_beat(ms, sec, mnt, hr, dd, mon, yr, wd));
        send_beat(tick_beat());
    endtask

    // Result side: check every beat the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_data);
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result-side stalls: random bursts, and one long hold-off that backs up the input.
    initial begin : result_stall
        int cycle;
        cycle   = 0;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle % 64 == 0) stall_odds = $urandom_range(0, 4);
            if (!hold_done && beats_in >= HOLD_AT) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm_tail && $urandom_range(1, 16) <= stall_odds) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int pick;
        int mon;
        int yr;
        sb      = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first tick from reset, field extremes and the calendar corner cases.
        send_beat(tick_beat());
        load_and_tick(1023, 63, 63, 31, 31, 15, 127, 7);
        load_and_tick(999, 59, 59, 23, 0, 0, 0, 0);
        load_and_tick(999, 59, 59, 23, 31, 12, 99, 7);
        load_and_tick(999, 59, 59, 23, 31, 12, 127, 3);
        load_and_tick(999, 59, 59, 23, 28, 2, 4, 5);
        load_and_tick(999, 59, 59, 23, 29, 2, 4, 6);
        load_and_tick(999, 59, 59, 23, 28, 2, 3, 2);
        load_and_tick(999, 59, 59, 23, 30, 4, 21, 1);
        load_and_tick(999, 59, 59, 23, 31, 4, 21, 6);
        load_and_tick(999, 59, 59, 23, 31, 13, 10, 6);
        load_and_tick(999, 30, 0, 0, 5, 6, 7, 4);
        load_and_tick(999, 59, 59, 22, 5, 6, 7, 4);

        // Random: mostly loads just short of a rollover followed by ticks across it.
        while (beats_in < TOTAL_BEATS) begin
            if (beats_in >= TOTAL_BEATS - CALM_BEATS) calm_tail = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                case ($urandom_range(0, 3))
                    0:       mon = 2;
                    1:       mon = 12;
                    default: mon = $urandom_range(0, 15);
                endcase
                case ($urandom_range(0, 3))
                    0:       yr = 99;
                    1:       yr = 4 * $urandom_range(0, 31);
                    default: yr = $urandom_range(0, 127);
                endcase
                send_beat(load_beat(rand_near(999, 1023), rand_near(59, 63), rand_near(59, 63),
                                    rand_near(23, 31),
                                    (pick < 4) ? $urandom_range(27, 31) : $urandom_range(0, 31),
                                    mon, yr, $urandom_range(0, 7)));
                repeat ($urandom_range(1, 4)) send_beat(tick_beat());
            end else if (pick < 9) begin
                // Plain tick runs keep the prescaler and tick count moving.
                repeat ($urandom_range(5, 60)) send_beat(tick_beat());
            end else begin
                send_beat(load_beat($urandom_range(0, 1023), $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 31),
                                    $urandom_range(0, 31), $urandom_range(0, 15),
                                    $urandom_range(0, 127), $urandom_range(0, 7)));
            end
        end
        i_valid <= 1'b0;

        // Drain the results still owed, then keep watching for stray beats.
        while (sb.expected_times.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_times.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
